// ===== hdl/cap_pkg.sv =====
`timescale 1ns / 1ps

package cap_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 17;
  localparam int LINE_W    = 20;
  localparam int POS_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int NUM_LINES = 6;

  localparam int DEF_COMB_LEN_A    = 1557;
  localparam int DEF_COMB_LEN_B    = 1617;
  localparam int DEF_COMB_LEN_C    = 1491;
  localparam int DEF_COMB_LEN_D    = 1422;
  localparam int DEF_ALLPASS_LEN_A = 225;
  localparam int DEF_ALLPASS_LEN_B = 556;

  localparam logic [COEF_W-1:0] Q16_ONE     = 17'd65536;
  localparam logic [COEF_W-1:0] COEF_RESET  = 17'd32768;
  localparam logic [16:0]       FB_BASE     = 17'd18350;
  localparam logic [17:0]       FB_SPAN     = 18'd36700;
  localparam logic [17:0]       WET_SCALE   = 18'd19661;

  localparam logic [CFG_IDX_W-1:0] REG_ROOM_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 1'd1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [COEF_W-1:0]          coef_t;
  typedef logic signed [LINE_W-1:0]   line_t;

  // round half up, drop 16 fraction bits
  function automatic logic signed [23:0] rshift16(input logic signed [39:0] v);
    logic signed [39:0] t;
    t = v + 40'sd32768;
    return t[39:16];
  endfunction

  function automatic line_t sat20(input logic signed [23:0] v);
    if (v > 24'sd524287) begin
      return 20'sd524287;
    end else if (v < -24'sd524288) begin
      return -20'sd524288;
    end
    return v[19:0];
  endfunction

  function automatic sample_t sat16(input logic signed [23:0] v);
    if (v > 24'sd32767) begin
      return 16'sd32767;
    end else if (v < -24'sd32768) begin
      return -16'sd32768;
    end
    return v[15:0];
  endfunction

  // round half up, halve
  function automatic line_t half20(input line_t v);
    logic signed [20:0] t;
    t = {v[19], v} + 21'sd1;
    return t[20:1];
  endfunction

endpackage

// ===== hdl/cap_if.sv =====
`timescale 1ns / 1ps

interface cap_in_if;
  import cap_pkg::*;
  logic    valid;
  logic    ready;
  sample_t in_sample;
  modport source (output valid, output in_sample, input ready);
  modport sink   (input valid, input in_sample, output ready);
endinterface

interface cap_out_if;
  import cap_pkg::*;
  logic    valid;
  logic    ready;
  sample_t out_sample;
  modport source (output valid, output out_sample, input ready);
  modport sink   (input valid, input out_sample, output ready);
endinterface

interface cap_cfg_if;
  import cap_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [COEF_W-1:0]    reg_data;
  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

// ===== hdl/comb_allpass_reverb.sv =====
`timescale 1ns / 1ps

// Schroeder reverberator: four feedback combs, two allpass stages, dry/wet mix.
// in_i carries one signed Q1.15 word per sample; out_o returns one mixed word
// per input word, in order. cfg_i writes room_size (index 0) or damping
// (index 1) as Q1.16, clamped to 1.0; cfg_i is always ready and must only be
// used while no sample is in flight.
// Each word is processed by one shared 21x18 multiplier, stepped through the
// feedback/wet coefficients, two products per comb and two for the mix, under
// a small sequencer. in_i is ready only in the idle state, so a new word is
// not accepted until the last one's result has reached the output register.
// Delay lines live in six single-port-per-direction RAMs addressed by their
// line positions; a line reads as zero until its position has wrapped once,
// so no clearing pass follows reset.
// Reset returns the coefficients to one half, the positions to zero and
// drops any pending result. If out_o is stalled the finished word waits in
// the output register and the sequencer holds before its last step.
module comb_allpass_reverb #(
  parameter int COMB_LEN_A    = cap_pkg::DEF_COMB_LEN_A,
  parameter int COMB_LEN_B    = cap_pkg::DEF_COMB_LEN_B,
  parameter int COMB_LEN_C    = cap_pkg::DEF_COMB_LEN_C,
  parameter int COMB_LEN_D    = cap_pkg::DEF_COMB_LEN_D,
  parameter int ALLPASS_LEN_A = cap_pkg::DEF_ALLPASS_LEN_A,
  parameter int ALLPASS_LEN_B = cap_pkg::DEF_ALLPASS_LEN_B
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cap_in_if.sink     in_i,
  cap_out_if.source  out_o,
  cap_cfg_if.sink    cfg_i
);

  import cap_pkg::*;

  localparam int LINE_LEN [NUM_LINES] = '{COMB_LEN_A, COMB_LEN_B, COMB_LEN_C,
                                          COMB_LEN_D, ALLPASS_LEN_A, ALLPASS_LEN_B};

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_FB   = 4'd1;
  localparam logic [3:0] ST_WET  = 4'd2;
  localparam logic [3:0] ST_C1   = 4'd3;
  localparam logic [3:0] ST_C2   = 4'd4;
  localparam logic [3:0] ST_CW   = 4'd5;
  localparam logic [3:0] ST_APA  = 4'd6;
  localparam logic [3:0] ST_APB  = 4'd7;
  localparam logic [3:0] ST_MIX1 = 4'd8;
  localparam logic [3:0] ST_MIX2 = 4'd9;
  localparam logic [3:0] ST_MIX3 = 4'd10;

  logic [3:0]              st_q, st_d;
  logic [1:0]              k_q, k_d;
  sample_t                 x_q;
  logic [16:0]             fb_q;
  logic [14:0]             wet_q;
  logic signed [21:0]      sum_q;
  line_t                   a_q;
  logic signed [38:0]      p_q;
  logic signed [38:0]      acc_q;
  logic [POS_W-1:0]        pos_q [NUM_LINES];
  logic [NUM_LINES-1:0]    full_q;
  coef_t                   room_q, damp_q;
  logic                    out_valid_q;
  sample_t                 out_q;

  line_t                   rdata [NUM_LINES];
  line_t                   rd [NUM_LINES];
  logic [NUM_LINES-1:0]    we;
  line_t                   wdata [NUM_LINES];

  logic                    in_acc, out_free, advance, mul_en;
  logic signed [20:0]      mul_a;
  logic signed [17:0]      mul_b;
  logic signed [23:0]      p_rnd;
  coef_t                   dg, dry, cfg_val;
  line_t                   d_k, comb_wdata, ap_in, ap_out;
  logic signed [21:0]      sum_base;

  assign in_i.ready      = (st_q == ST_IDLE);
  assign in_acc          = in_i.valid && in_i.ready;
  assign out_free        = !out_valid_q || out_o.ready;
  assign advance         = (st_q == ST_MIX3) && out_free;
  assign out_o.valid     = out_valid_q;
  assign out_o.out_sample = out_q;
  assign cfg_i.ready     = 1'b1;

  assign cfg_val = (cfg_i.reg_data > Q16_ONE) ? Q16_ONE : cfg_i.reg_data;
  assign dg      = Q16_ONE - {1'b0, damp_q[COEF_W-1:1]};
  assign dry     = Q16_ONE - {2'b0, wet_q};
  assign p_rnd   = rshift16({p_q[38], p_q});
  assign d_k     = rd[k_q];
  assign comb_wdata = sat20({{8{x_q[15]}}, x_q} + p_rnd);
  assign sum_base   = (k_q == 2'd0) ? 22'sd0 : sum_q;

  // allpass stage: first stage takes the comb average, second the first's output
  always_comb begin
    logic signed [21:0] avg_t;
    line_t              d_ap, h_d, h_a;
    avg_t = sum_q + 22'sd2;
    ap_in = (st_q == ST_APA) ? avg_t[21:2] : a_q;
    d_ap  = (st_q == ST_APA) ? rd[4] : rd[5];
    h_d   = half20(d_ap);
    h_a   = half20(ap_in);
    wdata[4] = sat20({{4{ap_in[19]}}, ap_in} + {{4{h_d[19]}}, h_d});
    wdata[5] = wdata[4];
    ap_out   = sat20({{4{d_ap[19]}}, d_ap} - {{4{h_a[19]}}, h_a});
    for (int j = 0; j < 4; j++) begin
      wdata[j] = comb_wdata;
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      we[j] = ((st_q == ST_C1) && (k_q != 2'd0) && (k_q - 2'd1 == 2'(j))) ||
              ((st_q == ST_CW) && (j == 3));
    end
    we[4] = (st_q == ST_APA);
    we[5] = (st_q == ST_APB);
  end

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (st_q)
      ST_FB: begin
        mul_a = {4'b0, room_q};
        mul_b = FB_SPAN;
      end
      ST_WET: begin
        mul_a = {4'b0, room_q};
        mul_b = WET_SCALE;
      end
      ST_C1: begin
        mul_a = {d_k[19], d_k};
        mul_b = {1'b0, dg};
      end
      ST_C2: begin
        mul_a = p_rnd[20:0];
        mul_b = {1'b0, fb_q};
      end
      ST_MIX1: begin
        mul_a = {{5{x_q[15]}}, x_q};
        mul_b = {1'b0, dry};
      end
      ST_MIX2: begin
        mul_a = {a_q[19], a_q};
        mul_b = {3'b0, wet_q};
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    st_d = st_q;
    k_d  = k_q;
    case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          st_d = ST_FB;
        end
      end
      ST_FB: st_d = ST_WET;
      ST_WET: begin
        k_d  = 2'd0;
        st_d = ST_C1;
      end
      ST_C1: st_d = ST_C2;
      ST_C2: begin
        if (k_q == 2'd3) begin
          st_d = ST_CW;
        end else begin
          k_d  = k_q + 2'd1;
          st_d = ST_C1;
        end
      end
      ST_CW:   st_d = ST_APA;
      ST_APA:  st_d = ST_APB;
      ST_APB:  st_d = ST_MIX1;
      ST_MIX1: st_d = ST_MIX2;
      ST_MIX2: st_d = ST_MIX3;
      ST_MIX3: begin
        if (out_free) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      k_q         <= '0;
      full_q      <= '0;
      room_q      <= COEF_RESET;
      damp_q      <= COEF_RESET;
      out_valid_q <= 1'b0;
      for (int j = 0; j < NUM_LINES; j++) begin
        pos_q[j] <= '0;
      end
    end else begin
      st_q <= st_d;
      k_q  <= k_d;
      if (cfg_i.valid) begin
        case (cfg_i.reg_index)
          REG_ROOM_SIZE: room_q <= cfg_val;
          REG_DAMPING:   damp_q <= cfg_val;
          default: ;
        endcase
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        for (int j = 0; j < NUM_LINES; j++) begin
          if ({1'b0, pos_q[j]} + 12'd1 >= 12'(LINE_LEN[j])) begin
            pos_q[j]  <= '0;
            full_q[j] <= 1'b1;
          end else begin
            pos_q[j] <= pos_q[j] + 1'b1;
          end
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q <= in_i.in_sample;
    end
    if (mul_en) begin
      p_q <= mul_a * mul_b;
    end
    case (st_q)
      ST_WET: fb_q <= FB_BASE + p_rnd[16:0];
      ST_C1: begin
        if (k_q == 2'd0) begin
          wet_q <= p_rnd[14:0];
        end
        sum_q <= sum_base + {{2{d_k[19]}}, d_k};
      end
      ST_APA, ST_APB: a_q <= ap_out;
      ST_MIX2: acc_q <= p_q;
      default: ;
    endcase
    if (advance) begin
      out_q <= sat16(rshift16({acc_q[38], acc_q} + {p_q[38], p_q}));
    end
  end

  for (genvar g = 0; g < NUM_LINES; g++) begin : g_line
    localparam int AW = $clog2(LINE_LEN[g]);

    cap_ram #(
      .WIDTH (LINE_W),
      .DEPTH (LINE_LEN[g])
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we[g]),
      .waddr_i (pos_q[g][AW-1:0]),
      .wdata_i (wdata[g]),
      .raddr_i (pos_q[g][AW-1:0]),
      .rdata_o (rdata[g])
    );

    // unwritten entries read as zero until the line wraps
    assign rd[g] = full_q[g] ? rdata[g] : '0;
  end

endmodule

// ===== hdl/cap_ram.sv =====
`timescale 1ns / 1ps

module cap_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
